/* src/sdt_pkg.sv */
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types for the surface damage tracker: controller states, output
// source select and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sdt_pkg;

    // Packed rectangle: x | y | w | h
    localparam int unsigned RECT_W = 62;
    localparam int unsigned GEN_W  = 32;
    localparam int unsigned ID_W   = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_READ,
        ST_DECIDE,
        ST_EMIT_OLD,
        ST_EMIT_NEW,
        ST_EOF_FIND,
        ST_EOF_CHECK,
        ST_EOF_READ,
        ST_EOF_EMIT,
        ST_EOF_DONE
    } t_state;

    typedef enum logic [1:0] {
        SRC_NEW,
        SRC_OLD,
        SRC_DONE
    } t_out_src;

    typedef struct packed {
        logic     capture;
        logic     lookup;
        logic     rd_prev;
        logic     find_eof;
        logic     rd_eof;
        logic     record;
        logic     load_out;
        t_out_src out_src;
        logic     out_last;
        logic     out_full;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic has_prev;
        logic has_now;
        logic has_free;
        logic prev_seen;
        logic rect_diff;
        logic gen_diff;
        logic full;
        logic eof_any;
        logic out_free;
    } t_dp_sts;

endpackage

/* src/surface_damage_tracker_unit.sv */
// ----------------------------------------------------------------------------
// surface_damage_tracker_unit
// Per-frame surface tracker that emits damage rectangles for placements and
// stale surfaces at end of frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | req_type, id, rect, generation
//  output  | out       | o_out_valid / i_out_stall  | kind, rect, last, table_full
//
// A placement steps through accept, lookup, table read and decision, then loads
// its results; a second result waits for the output register to drain.
// End of frame finds, reads and emits each stale surface, then a done marker.
// Reset (synchronous, active low) clears the slot flags and output valid.
// A stalled output holds the controller in its emit state; no input is taken
// until the current transaction's results are all loaded.
// ----------------------------------------------------------------------------
module surface_damage_tracker_unit #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_surface_id,
    input  logic [15:0] i_dest_x,
    input  logic [15:0] i_dest_y,
    input  logic [14:0] i_dest_w,
    input  logic [14:0] i_dest_h,
    input  logic [31:0] i_frame_gen,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [15:0] o_damage_x,
    output logic [15:0] o_damage_y,
    output logic [14:0] o_damage_w,
    output logic [14:0] o_damage_h,
    output logic        o_last,
    output logic        o_table_full
);
    import sdt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    sdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sdt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_surface_id (i_surface_id),
        .i_dest_x     (i_dest_x),
        .i_dest_y     (i_dest_y),
        .i_dest_w     (i_dest_w),
        .i_dest_h     (i_dest_h),
        .i_frame_gen  (i_frame_gen),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_kind       (o_kind),
        .o_damage_x   (o_damage_x),
        .o_damage_y   (o_damage_y),
        .o_damage_w   (o_damage_w),
        .o_damage_h   (o_damage_h),
        .o_last       (o_last),
        .o_table_full (o_table_full)
    );

endmodule

/* src/sdt_ctrl.sv */
// ----------------------------------------------------------------------------
// sdt_ctrl
// Controller: sequences lookup, table read, decision, result emission and the
// end-of-frame sweep over stale surfaces.
// ----------------------------------------------------------------------------
module sdt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_req_type,
    output logic             o_in_stall,
    input  sdt_pkg::t_dp_sts i_sts,
    output sdt_pkg::t_dp_cmd o_cmd
);
    import sdt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.out_src = SRC_NEW;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_req_type ? ST_EOF_FIND : ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd_prev = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                // record first placement of a known surface, or a new one with room
                o_cmd.record = (i_sts.has_prev && !i_sts.prev_seen) ||
                               (!i_sts.has_prev && !i_sts.has_now && i_sts.has_free);
                if (!i_sts.has_prev || (!i_sts.rect_diff && i_sts.gen_diff)) begin
                    n_state = ST_EMIT_NEW;
                end else if (i_sts.rect_diff) begin
                    n_state = ST_EMIT_OLD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_OLD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_src  = SRC_OLD;
                    n_state = ST_EMIT_NEW;
                end
            end
            ST_EMIT_NEW: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_src  = SRC_NEW;
                    o_cmd.out_last = 1'b1;
                    o_cmd.out_full = i_sts.full;
                    n_state = ST_IDLE;
                end
            end
            ST_EOF_FIND: begin
                o_cmd.find_eof = 1'b1;
                n_state = ST_EOF_CHECK;
            end
            ST_EOF_CHECK: begin
                n_state = i_sts.eof_any ? ST_EOF_READ : ST_EOF_DONE;
            end
            ST_EOF_READ: begin
                o_cmd.rd_eof = 1'b1;
                n_state = ST_EOF_EMIT;
            end
            ST_EOF_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_src  = SRC_OLD;
                    n_state = ST_EOF_FIND;
                end
            end
            ST_EOF_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_src  = SRC_DONE;
                    o_cmd.out_last = 1'b1;
                    o_cmd.commit   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/sdt_dpath.sv */
// ----------------------------------------------------------------------------
// sdt_dpath
// Datapath: id match array, slot flags, two-bank rectangle/generation memory
// and the output register.
// ----------------------------------------------------------------------------
module sdt_dpath #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sdt_pkg::t_dp_cmd i_cmd,
    output sdt_pkg::t_dp_sts o_sts,
    input  logic [31:0]      i_surface_id,
    input  logic [15:0]      i_dest_x,
    input  logic [15:0]      i_dest_y,
    input  logic [14:0]      i_dest_w,
    input  logic [14:0]      i_dest_h,
    input  logic [31:0]      i_frame_gen,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic             o_kind,
    output logic [15:0]      o_damage_x,
    output logic [15:0]      o_damage_y,
    output logic [14:0]      o_damage_w,
    output logic [14:0]      o_damage_h,
    output logic             o_last,
    output logic             o_table_full
);
    import sdt_pkg::*;

    localparam int unsigned SLOT_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned MEM_DEPTH = 2 ** (SLOT_W + 1);
    localparam int unsigned DATA_W    = RECT_W + GEN_W;

    // Captured item
    logic [ID_W-1:0]   r_id;
    logic [RECT_W-1:0] r_rect;
    logic [GEN_W-1:0]  r_gen;

    // Slot flags and ids
    logic [TABLE_DEPTH-1:0] r_prev_valid;
    logic [TABLE_DEPTH-1:0] r_seen;
    logic [TABLE_DEPTH-1:0] r_bank;
    logic [TABLE_DEPTH-1:0] r_scan;
    logic [ID_W-1:0]        r_entry_id [TABLE_DEPTH];

    // Lookup results
    logic              r_has_prev, r_has_now, r_has_free, r_eof_any;
    logic [SLOT_W-1:0] r_prev_slot, r_free_slot, r_eof_slot;

    // Bank memory: address {bank, slot}
    logic [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Output register
    logic              r_out_valid, r_kind, r_last, r_full;
    logic [RECT_W-1:0] r_out_rect;

    // Lowest set bit
    function automatic logic [SLOT_W-1:0] first_set(input logic [TABLE_DEPTH-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (v[i]) idx = SLOT_W'(i);
        end
        return idx;
    endfunction

    logic [TABLE_DEPTH-1:0] match_prev, match_now, free_vec;
    logic [SLOT_W-1:0]      rec_slot;
    logic [SLOT_W-1:0]      rd_slot;
    logic                   rd_en;

    // Parallel id compare
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match_prev[i] = r_prev_valid[i] && (r_entry_id[i] == r_id);
            match_now[i]  = r_seen[i] && (r_entry_id[i] == r_id);
            free_vec[i]   = !r_prev_valid[i] && !r_seen[i];
        end
    end

    assign rec_slot = r_has_prev ? r_prev_slot : r_free_slot;
    assign rd_slot  = i_cmd.rd_eof ? r_eof_slot : r_prev_slot;
    assign rd_en    = i_cmd.rd_prev || i_cmd.rd_eof;

    // Capture and lookup registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id   <= i_surface_id;
            r_rect <= {i_dest_x, i_dest_y, i_dest_w, i_dest_h};
            r_gen  <= i_frame_gen;
        end
        if (i_cmd.lookup) begin
            r_has_prev  <= |match_prev;
            r_has_now   <= |match_now;
            r_has_free  <= |free_vec;
            r_prev_slot <= first_set(match_prev);
            r_free_slot <= first_set(free_vec);
        end
        if (i_cmd.find_eof) begin
            r_eof_any  <= |r_scan;
            r_eof_slot <= first_set(r_scan);
        end
        if (i_cmd.record && !r_has_prev) begin
            r_entry_id[rec_slot] <= r_id;
        end
    end

    // Slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= '0;
            r_seen       <= '0;
            r_bank       <= '0;
            r_scan       <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_scan <= r_prev_valid & ~r_seen;
            end
            if (i_cmd.rd_eof) begin
                r_scan[r_eof_slot] <= 1'b0;
            end
            if (i_cmd.record) begin
                r_seen[rec_slot] <= 1'b1;
            end
            // current frame becomes previous: flip bank where recorded
            if (i_cmd.commit) begin
                r_prev_valid <= r_seen;
                r_bank       <= r_bank ^ r_seen;
                r_seen       <= '0;
            end
        end
    end

    // Bank memory: previous in bank r_bank[slot], current in the other
    always_ff @(posedge i_clk) begin
        if (i_cmd.record) begin
            r_mem[{~r_bank[rec_slot], rec_slot}] <= {r_rect, r_gen};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[{r_bank[rd_slot], rd_slot}];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_last <= i_cmd.out_last;
            r_full <= i_cmd.out_full;
            case (i_cmd.out_src)
                SRC_OLD: begin
                    r_kind     <= 1'b0;
                    r_out_rect <= r_rd_data[DATA_W-1:GEN_W];
                end
                SRC_DONE: begin
                    r_kind     <= 1'b1;
                    r_out_rect <= '0;
                end
                default: begin
                    r_kind     <= 1'b0;
                    r_out_rect <= r_rect;
                end
            endcase
        end
    end

    // Status
    always_comb begin
        o_sts.has_prev  = r_has_prev;
        o_sts.has_now   = r_has_now;
        o_sts.has_free  = r_has_free;
        o_sts.prev_seen = r_seen[r_prev_slot];
        o_sts.rect_diff = r_rd_data[DATA_W-1:GEN_W] != r_rect;
        o_sts.gen_diff  = r_rd_data[GEN_W-1:0] != r_gen;
        o_sts.full      = !r_has_prev && !r_has_now && !r_has_free;
        o_sts.eof_any   = r_eof_any;
        o_sts.out_free  = !r_out_valid;
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_damage_x   = r_out_rect[61:46];
    assign o_damage_y   = r_out_rect[45:30];
    assign o_damage_w   = r_out_rect[29:15];
    assign o_damage_h   = r_out_rect[14:0];
    assign o_last       = r_last;
    assign o_table_full = r_full;

endmodule
